// ----- hdl/bun_pkg.sv -----
// Shared types, codes and constants for the box-union novelty table.
package bun_pkg;

    // Default parameter values
    localparam int DEF_MAX_DIMS   = 4;
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_COORD_BITS = 16;

    // Fixed field widths of the ports
    localparam int NUM_COORDS     = 4;
    localparam int LANE_BITS      = 16;
    localparam int PACKED_BITS    = NUM_COORDS * LANE_BITS;
    localparam int DIMS_BITS      = 3;
    localparam int NUM_BOXES_BITS = 7;
    localparam int NOVEL_CNT_BITS = 32;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 64;

    // Configuration reset values
    localparam logic [DIMS_BITS-1:0]   DIMS_RESET  = DIMS_BITS'(4);
    localparam logic [LANE_BITS-1:0]   EPS_RESET   = '0;
    localparam logic [PACKED_BITS-1:0] DMIN_RESET  = '0;
    localparam logic [PACKED_BITS-1:0] DMAX_RESET  = '1;

    // Operation codes
    typedef enum logic [1:0] {
        OP_OBSERVE = 2'd0,
        OP_QUERY   = 2'd1,
        OP_CLEAR   = 2'd2
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DIMS = 3'd0,
        CFG_EPS  = 3'd1,
        CFG_DMIN = 3'd2,
        CFG_DMAX = 3'd3
    } t_cfg_idx;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DONE
    } t_state;

    // Input item
    typedef struct packed {
        logic [1:0]           op;
        logic [LANE_BITS-1:0] coord0;
        logic [LANE_BITS-1:0] coord1;
        logic [LANE_BITS-1:0] coord2;
        logic [LANE_BITS-1:0] coord3;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]                status;
        logic                      novel;
        logic [NUM_BOXES_BITS-1:0] num_boxes;
        logic [NOVEL_CNT_BITS-1:0] novel_count;
    } t_out_item;

    // Configuration registers as seen by the controller
    typedef struct packed {
        logic [DIMS_BITS-1:0]   dims;
        logic [LANE_BITS-1:0]   epsilon;
        logic [PACKED_BITS-1:0] dom_min;
        logic [PACKED_BITS-1:0] dom_max;
    } t_cfg;

endpackage

// ----- hdl/bun_box_mem.sv -----
// Box store: one synchronous memory, one write and one registered read port.
module bun_box_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/bun_ctrl.sv -----
// Controller: domain check, box scan over the store, append and counters.
module bun_ctrl #(
    parameter int MAX_DIMS   = 4,
    parameter int CAPACITY   = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bun_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bun_pkg::t_in_item             i_in,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output bun_pkg::t_out_item            o_res,
    output logic                          o_mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0]   o_mem_wr_addr,
    output logic [2*MAX_DIMS*COORD_BITS-1:0] o_mem_wr_data,
    output logic                          o_mem_rd_en,
    output logic [$clog2(CAPACITY)-1:0]   o_mem_rd_addr,
    input  logic [2*MAX_DIMS*COORD_BITS-1:0] i_mem_rd_data
);
    import bun_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int BOXW  = MAX_DIMS * COORD_BITS;

    typedef logic [MAX_DIMS-1:0][COORD_BITS-1:0] t_lanes;

    t_state r_state, n_state;

    logic [1:0]                r_op;
    t_lanes                    r_pt;
    t_lanes                    r_box_lo, r_box_hi;
    logic                      r_in_dom;
    logic                      r_hit, n_hit;
    logic                      r_pend, n_pend;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [NOVEL_CNT_BITS-1:0] r_total, n_total;

    logic [NUM_COORDS-1:0][LANE_BITS-1:0] in_coords;
    logic [MAX_DIMS-1:0] lane_en;
    logic                in_dom;
    t_lanes              box_lo, box_hi;
    t_lanes              rd_lo, rd_hi;
    logic                hit_now;
    logic                more;
    logic                full;
    t_out_item           res;

    assign in_coords = {i_in.coord3, i_in.coord2, i_in.coord1, i_in.coord0};

    // Dimensions compared: dims of zero acts as one, above MAX_DIMS as all
    always_comb begin
        for (int i = 0; i < MAX_DIMS; i++) begin
            lane_en[i] = (i == 0) || (DIMS_BITS'(i) < i_cfg.dims);
        end
    end

    // Domain check and clipped box of the held point
    always_comb begin
        logic [COORD_BITS-1:0] eps;
        logic [COORD_BITS-1:0] mn, mx, lo;
        logic [COORD_BITS:0]   hi;
        eps    = i_cfg.epsilon[COORD_BITS-1:0];
        in_dom = 1'b1;
        for (int i = 0; i < MAX_DIMS; i++) begin
            mn = i_cfg.dom_min[LANE_BITS*i +: COORD_BITS];
            mx = i_cfg.dom_max[LANE_BITS*i +: COORD_BITS];
            if (lane_en[i] && ((r_pt[i] < mn) || (r_pt[i] > mx))) begin
                in_dom = 1'b0;
            end
            lo = (r_pt[i] >= eps) ? (r_pt[i] - eps) : '0;
            if (lo < mn) begin
                lo = mn;
            end
            hi = {1'b0, r_pt[i]} + {1'b0, eps};
            if (hi > {1'b0, mx}) begin
                hi = {1'b0, mx};
            end
            box_lo[i] = lo;
            box_hi[i] = hi[COORD_BITS-1:0];
        end
    end

    // Containment test of the box just read
    assign rd_lo = i_mem_rd_data[BOXW-1:0];
    assign rd_hi = i_mem_rd_data[2*BOXW-1:BOXW];

    always_comb begin
        logic in_box;
        in_box = 1'b1;
        for (int i = 0; i < MAX_DIMS; i++) begin
            if (lane_en[i] && ((r_pt[i] < rd_lo[i]) || (r_pt[i] > rd_hi[i]))) begin
                in_box = 1'b0;
            end
        end
        hit_now = r_pend && in_box;
    end

    assign more = (r_idx < r_count);
    assign full = (r_count >= CNT_W'(CAPACITY));

    // Point capture and box registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op <= i_in.op;
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_pt[i] <= in_coords[i][COORD_BITS-1:0];
            end
        end
        if (r_state == S_CHECK) begin
            r_in_dom <= in_dom;
            r_box_lo <= box_lo;
            r_box_hi <= box_hi;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hit   <= 1'b0;
            r_pend  <= 1'b0;
            r_idx   <= '0;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
            r_pend  <= n_pend;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    // Next state, memory access and result
    always_comb begin
        n_state       = r_state;
        n_hit         = r_hit;
        n_pend        = r_pend;
        n_idx         = r_idx;
        n_count       = r_count;
        n_total       = r_total;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_idx[AW-1:0];
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_count[AW-1:0];
        o_mem_wr_data = {r_box_hi, r_box_lo};
        o_res_valid   = 1'b0;
        res.status    = STAT_OK;
        res.novel     = 1'b0;
        res.num_boxes = NUM_BOXES_BITS'(r_count);
        res.novel_count = r_total;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_hit  = 1'b0;
                n_pend = 1'b0;
                n_idx  = '0;
                if ((r_op == OP_OBSERVE || r_op == OP_QUERY) && in_dom
                        && (r_count != '0)) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                // one read issued per cycle, compared in the cycle after
                if (hit_now) begin
                    n_hit   = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else if (more) begin
                    o_mem_rd_en = 1'b1;
                    n_idx       = r_idx + 1'b1;
                    n_pend      = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                priority if (r_op == OP_CLEAR) begin
                    n_count = '0;
                    n_total = '0;
                end else if (r_op == OP_OBSERVE) begin
                    if (!r_in_dom) begin
                        res.status = STAT_RANGE;
                    end else if (full) begin
                        res.status = STAT_FULL;
                    end else begin
                        res.novel = !r_hit;
                        n_count   = r_count + 1'b1;
                        if (!r_hit && (r_total != '1)) begin
                            n_total = r_total + 1'b1;
                        end
                    end
                end else if (r_op == OP_QUERY) begin
                    if (!r_in_dom) begin
                        res.status = STAT_RANGE;
                    end else begin
                        res.novel = !r_hit;
                    end
                end else begin
                    res.status = STAT_OK;
                end
                res.num_boxes   = NUM_BOXES_BITS'(n_count);
                res.novel_count = n_total;
                if (i_res_ready) begin
                    o_mem_wr_en = (r_op == OP_OBSERVE) && r_in_dom && !full;
                    n_state     = S_IDLE;
                end else begin
                    n_count = r_count;
                    n_total = r_total;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_res      = res;

endmodule

// ----- hdl/box_union_novelty_table_unit.sv -----
// Box-union novelty table: top level with configuration and output registers.
// Each item passes the states IDLE, CHECK, SCAN when needed, and DONE, then the output
// register; a scan stops at the first covering box.
// A new item is taken only in IDLE, once the last one has left DONE; during a scan the
// box memory delivers one stored box per cycle to the containment compare.
// Reset: counters clear, registers take defaults; box memory is left as is.
module box_union_novelty_table_unit #(
    parameter int MAX_DIMS   = bun_pkg::DEF_MAX_DIMS,
    parameter int CAPACITY   = bun_pkg::DEF_CAPACITY,
    parameter int COORD_BITS = bun_pkg::DEF_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bun_pkg::t_in_item                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bun_pkg::t_out_item                o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bun_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bun_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import bun_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int MEMW = 2 * MAX_DIMS * COORD_BITS;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out;

    logic            res_valid, res_ready;
    t_out_item       res;
    logic            mem_wr_en, mem_rd_en;
    logic [AW-1:0]   mem_wr_addr, mem_rd_addr;
    logic [MEMW-1:0] mem_wr_data, mem_rd_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dims    <= DIMS_RESET;
            r_cfg.epsilon <= EPS_RESET;
            r_cfg.dom_min <= DMIN_RESET;
            r_cfg.dom_max <= DMAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIMS: r_cfg.dims    <= i_cfg_data[DIMS_BITS-1:0];
                CFG_EPS:  r_cfg.epsilon <= i_cfg_data[LANE_BITS-1:0];
                CFG_DMIN: r_cfg.dom_min <= i_cfg_data[PACKED_BITS-1:0];
                CFG_DMAX: r_cfg.dom_max <= i_cfg_data[PACKED_BITS-1:0];
                default:  ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Output register: frees the controller while a result waits
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    bun_ctrl #(
        .MAX_DIMS   (MAX_DIMS),
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (i_in),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data)
    );

    bun_box_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (MEMW)
    ) u_box_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

endmodule

// ----- bench/box_union_novelty_table_unit_chk.sv -----
// Checker for the box-union novelty table: predicts each result and compares it.
`timescale 1ns / 1ps

module box_union_novelty_table_unit_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  bun_pkg::t_in_item                 i_in,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  bun_pkg::t_out_item                i_out,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [bun_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bun_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import bun_pkg::*;

    localparam int MAX_DIMS     = DEF_MAX_DIMS;
    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int REPORT_LIMIT = 10;

    // Shadow configuration
    logic [DIMS_BITS-1:0]      cfg_dims;
    logic [LANE_BITS-1:0]      cfg_eps;
    logic [PACKED_BITS-1:0]    cfg_dmin;
    logic [PACKED_BITS-1:0]    cfg_dmax;

    // Shadow box table and counters
    logic [PACKED_BITS-1:0]    box_lo [CAPACITY];
    logic [PACKED_BITS-1:0]    box_hi [CAPACITY];
    int                        box_cnt;
    logic [NOVEL_CNT_BITS-1:0] novel_tot;

    t_out_item                 verdict_q [$];
    t_out_item                 want;
    int                        fails = 0;

    // Applies one item to the shadow table and returns the result it must give
    function automatic t_out_item judge_point(input t_in_item item);
        logic [LANE_BITS-1:0]   pt [NUM_COORDS];
        logic [LANE_BITS-1:0]   mn;
        logic [LANE_BITS-1:0]   mx;
        logic [LANE_BITS:0]     lo;
        logic [LANE_BITS:0]     hi;
        logic [PACKED_BITS-1:0] lo_word;
        logic [PACKED_BITS-1:0] hi_word;
        int                     nd;
        int                     i;
        int                     j;
        bit                     in_dom;
        bit                     covered;
        bit                     in_box;
        t_out_item              res;

        pt[0] = item.coord0;
        pt[1] = item.coord1;
        pt[2] = item.coord2;
        pt[3] = item.coord3;
        // zero dims behaves as one, anything past the lane count as all lanes
        if (cfg_dims < 1)
            nd = 1;
        else if (cfg_dims > MAX_DIMS)
            nd = MAX_DIMS;
        else
            nd = int'(cfg_dims);
        res = '0;

        case (item.op)
            OP_CLEAR: begin
                box_cnt   = 0;
                novel_tot = '0;
            end
            OP_OBSERVE, OP_QUERY: begin
                // domain check first; an inverted lane rejects everything
                in_dom = 1'b1;
                for (i = 0; i < nd; i++) begin
                    if (pt[i] < cfg_dmin[i*LANE_BITS +: LANE_BITS] ||
                        pt[i] > cfg_dmax[i*LANE_BITS +: LANE_BITS])
                        in_dom = 1'b0;
                end
                if (!in_dom) begin
                    res.status = STAT_RANGE;
                end else begin
                    // closed-bound containment over the compared lanes
                    covered = 1'b0;
                    for (j = 0; j < box_cnt && !covered; j++) begin
                        in_box = 1'b1;
                        for (i = 0; i < nd; i++) begin
                            if (pt[i] < box_lo[j][i*LANE_BITS +: LANE_BITS] ||
                                pt[i] > box_hi[j][i*LANE_BITS +: LANE_BITS])
                                in_box = 1'b0;
                        end
                        covered = in_box;
                    end
                    if (item.op == OP_QUERY) begin
                        res.novel = !covered;
                    end else if (box_cnt >= CAPACITY) begin
                        res.status = STAT_FULL;
                    end else begin
                        // new box is point +- epsilon, saturated into the domain
                        for (i = 0; i < NUM_COORDS; i++) begin
                            mn = cfg_dmin[i*LANE_BITS +: LANE_BITS];
                            mx = cfg_dmax[i*LANE_BITS +: LANE_BITS];
                            lo = (pt[i] >= cfg_eps) ? {1'b0, pt[i]} - {1'b0, cfg_eps} : '0;
                            hi = {1'b0, pt[i]} + {1'b0, cfg_eps};
                            if (lo < {1'b0, mn})
                                lo = {1'b0, mn};
                            if (hi > {1'b0, mx})
                                hi = {1'b0, mx};
                            lo_word[i*LANE_BITS +: LANE_BITS] = lo[LANE_BITS-1:0];
                            hi_word[i*LANE_BITS +: LANE_BITS] = hi[LANE_BITS-1:0];
                        end
                        box_lo[box_cnt] = lo_word;
                        box_hi[box_cnt] = hi_word;
                        box_cnt++;
                        res.novel = !covered;
                        if (!covered && novel_tot != '1)
                            novel_tot++;
                    end
                end
            end
            default: ;
        endcase

        res.num_boxes   = NUM_BOXES_BITS'(box_cnt);
        res.novel_count = novel_tot;
        return res;
    endfunction

    // Watch the three channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_dims  = DIMS_RESET;
            cfg_eps   = EPS_RESET;
            cfg_dmin  = DMIN_RESET;
            cfg_dmax  = DMAX_RESET;
            box_cnt   = 0;
            novel_tot = '0;
            verdict_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DIMS: cfg_dims = i_cfg_data[DIMS_BITS-1:0];
                    CFG_EPS:  cfg_eps  = i_cfg_data[LANE_BITS-1:0];
                    CFG_DMIN: cfg_dmin = i_cfg_data;
                    CFG_DMAX: cfg_dmax = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready)
                verdict_q.push_back(judge_point(i_in));

            // fields are printed as status/novel/boxes/count
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    if (fails < REPORT_LIMIT)
                        $display("%0t: unexpected result %0d/%0d/%0d/%0d",
                                 $time, i_out.status, i_out.novel, i_out.num_boxes,
                                 i_out.novel_count);
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    if (want.status !== i_out.status || want.novel !== i_out.novel ||
                        want.num_boxes !== i_out.num_boxes ||
                        want.novel_count !== i_out.novel_count) begin
                        if (fails < REPORT_LIMIT)
                            $display("%0t: mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     $time, want.status, want.novel, want.num_boxes,
                                     want.novel_count, i_out.status, i_out.novel,
                                     i_out.num_boxes, i_out.novel_count);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= verdict_q.size();
    end

endmodule

// ----- bench/box_union_novelty_table_unit_tb.sv -----
// Testbench top for the box-union novelty table: stimulus, idling and verdict.
`timescale 1ns / 1ps

module box_union_novelty_table_unit_tb;
    import bun_pkg::*;

    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 12;
    localparam int RESET_CYCLES = 4;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int POOL_SIZE    = 16;
    localparam int LANE_TOP     = (1 << LANE_BITS) - 1;
    localparam int IDX_TOP      = (1 << CFG_IDX_BITS) - 1;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Idling modes
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    t_in_item                 i_in        = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    t_out_item                o_out;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    int                       fail_count;
    int                       pending;
    int                       send_idle_pct  = 0;
    int                       recv_stall_pct = 0;

    // Copy of the programmed domain and epsilon, used to aim the points
    logic [LANE_BITS-1:0]     cur_eps  = EPS_RESET;
    logic [PACKED_BITS-1:0]   cur_dmin = DMIN_RESET;
    logic [PACKED_BITS-1:0]   cur_dmax = DMAX_RESET;

    // Recently observed points, reused to land inside or on the edge of boxes
    logic [PACKED_BITS-1:0]   recent_pts [POOL_SIZE];
    int                       recent_n = 0;

    box_union_novelty_table_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    box_union_novelty_table_unit_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result-side backpressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transfer
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** box_union_novelty_table_unit: FAILED **");
        $finish;
    end

    function automatic t_in_item point_item(input logic [1:0] op, input int c0, input int c1,
                                            input int c2, input int c3);
        t_in_item item;
        item.op     = op;
        item.coord0 = LANE_BITS'(c0);
        item.coord1 = LANE_BITS'(c1);
        item.coord2 = LANE_BITS'(c2);
        item.coord3 = LANE_BITS'(c3);
        return item;
    endfunction

    // Random item: mostly near earlier points or inside the domain, some noise
    function automatic t_in_item pick_item();
        t_in_item               item;
        logic [PACKED_BITS-1:0] base_pt;
        logic [LANE_BITS-1:0]   pt [NUM_COORDS];
        int                     r;
        int                     mode;
        int                     i;
        int                     v;
        int                     eps;
        int                     span;
        int                     pool_n;

        r = $urandom_range(0, 999);
        if (r < 6)
            item.op = OP_CLEAR;
        else if (r < 26)
            item.op = OP_UNUSED;
        else if (r < 560)
            item.op = OP_OBSERVE;
        else
            item.op = OP_QUERY;

        mode    = $urandom_range(0, 9);
        pool_n  = (recent_n < POOL_SIZE) ? recent_n : POOL_SIZE;
        base_pt = (pool_n > 0) ? recent_pts[$urandom_range(0, pool_n - 1)] : '0;
        eps     = int'(cur_eps);
        span    = (eps + 2 > 4096) ? 4096 : eps + 2;

        for (i = 0; i < NUM_COORDS; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                v = $urandom_range(0, 1) ? LANE_TOP : 0;
            end else if (mode < 6 && pool_n > 0) begin
                v = int'(base_pt[i*LANE_BITS +: LANE_BITS]);
                // hit the closed box edges and just past them, or somewhere near
                case ($urandom_range(0, 7))
                    0: v = v + eps;
                    1: v = v - eps;
                    2: v = v + eps + 1;
                    3: v = v - eps - 1;
                    default: v = v + int'($urandom_range(0, 2 * span)) - span;
                endcase
            end else if (mode < 9) begin
                v = $urandom_range(cur_dmax[i*LANE_BITS +: LANE_BITS],
                                   cur_dmin[i*LANE_BITS +: LANE_BITS]);
            end else begin
                v = $urandom_range(0, LANE_TOP);
            end
            if (v < 0)
                v = 0;
            if (v > LANE_TOP)
                v = LANE_TOP;
            pt[i] = LANE_BITS'(v);
        end
        item.coord0 = pt[0];
        item.coord1 = pt[1];
        item.coord2 = pt[2];
        item.coord3 = pt[3];
        return item;
    endfunction

    // One input transfer; valid stays high into the next item unless a gap is drawn
    task automatic send_point(input t_in_item item);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (item.op == OP_OBSERVE) begin
            recent_pts[recent_n % POOL_SIZE] = {item.coord3, item.coord2, item.coord1,
                                                item.coord0};
            recent_n++;
        end
    endtask

    // Stop sending and wait until every result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    // One register write transfer; valid is lowered by cfg_close after a group
    task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_EPS:  cur_eps  = data[LANE_BITS-1:0];
            CFG_DMIN: cur_dmin = data;
            CFG_DMAX: cur_dmax = data;
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            IDLE_SEND: begin
                send_idle_pct  = 71;
                recv_stall_pct <= 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct <= 71;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 36;
                recv_stall_pct <= 36;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct <= 0;
            end
        endcase
    endtask

    // Random settings for one phase, extremes included now and then
    task automatic setup_phase();
        logic [CFG_DATA_BITS-1:0] data;
        logic [PACKED_BITS-1:0]   dmin;
        logic [PACKED_BITS-1:0]   dmax;
        logic [LANE_BITS-1:0]     a;
        logic [LANE_BITS-1:0]     b;
        logic [LANE_BITS-1:0]     lo_l;
        logic [LANE_BITS-1:0]     hi_l;
        int                       r;
        int                       i;

        // writes to unmapped indexes must change nothing
        if ($urandom_range(0, 3) == 0)
            set_reg(CFG_IDX_BITS'($urandom_range(CFG_DMAX + 1, IDX_TOP)), {$urandom, $urandom});

        data = {$urandom, $urandom};
        r    = $urandom_range(0, 9);
        data[DIMS_BITS-1:0] = (r < 8) ? DIMS_BITS'(r % 4 + 1)
                                      : DIMS_BITS'($urandom_range(0, (1 << DIMS_BITS) - 1));
        set_reg(CFG_DIMS, data);

        data = {$urandom, $urandom};
        r    = $urandom_range(0, 9);
        if (r == 0)
            data[LANE_BITS-1:0] = '0;
        else if (r == 1)
            data[LANE_BITS-1:0] = '1;
        else if (r < 6)
            data[LANE_BITS-1:0] = LANE_BITS'($urandom_range(0, 16));
        else if (r < 9)
            data[LANE_BITS-1:0] = LANE_BITS'($urandom_range(0, 1024));
        set_reg(CFG_EPS, data);

        for (i = 0; i < NUM_COORDS; i++) begin
            r = $urandom_range(0, 39);
            a = LANE_BITS'($urandom);
            b = LANE_BITS'($urandom);
            if (r < 16) begin
                lo_l = '0;
                hi_l = '1;
            end else if (r < 30) begin
                lo_l = (a < b) ? a : b;
                hi_l = (a < b) ? b : a;
            end else if (r < 37) begin
                // narrow band so that boxes get clipped
                lo_l = a;
                hi_l = (int'(a) > LANE_TOP - 64) ? '1 : a + LANE_BITS'($urandom_range(0, 64));
            end else if (r < 39) begin
                lo_l = a;
                hi_l = a;
            end else begin
                // inverted bounds: empty domain in this lane
                lo_l = (a < b) ? b : a;
                hi_l = (a < b) ? a : b;
            end
            dmin[i*LANE_BITS +: LANE_BITS] = lo_l;
            dmax[i*LANE_BITS +: LANE_BITS] = hi_l;
        end
        set_reg(CFG_DMIN, dmin);
        set_reg(CFG_DMAX, dmax);
        cfg_close();
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        int phase;
        int n;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idle(IDLE_NONE);

        // Reset settings: full domain, all four lanes, point boxes
        send_point(point_item(OP_OBSERVE, 0, 0, 0, 0));
        send_point(point_item(OP_QUERY, 0, 0, 0, 0));
        send_point(point_item(OP_OBSERVE, LANE_TOP, LANE_TOP, LANE_TOP, LANE_TOP));
        send_point(point_item(OP_QUERY, LANE_TOP, LANE_TOP, LANE_TOP, 0));
        send_point(point_item(OP_UNUSED, LANE_TOP, LANE_TOP, LANE_TOP, LANE_TOP));
        send_point(point_item(OP_CLEAR, 0, 0, 0, 0));

        // Zero dims acts as one lane; widest epsilon; junk in the upper data bits
        wait_drained();
        set_reg(CFG_DIMS, 64'hFFFF_FFFF_FFFF_FFF8);
        set_reg(CFG_EPS, 64'h0123_4567_89AB_FFFF);
        set_reg(CFG_DMIN, '0);
        set_reg(CFG_DMAX, '1);
        cfg_close();
        send_point(point_item(OP_OBSERVE, 16'h8000, 1, 2, 3));
        send_point(point_item(OP_QUERY, 0, LANE_TOP, LANE_TOP, LANE_TOP));
        send_point(point_item(OP_QUERY, LANE_TOP, 0, 0, 0));
        send_point(point_item(OP_CLEAR, LANE_TOP, LANE_TOP, LANE_TOP, LANE_TOP));

        // Dims above the lane count act as all lanes; bounded domain, epsilon one
        wait_drained();
        set_reg(CFG_DIMS, 64'd7);
        set_reg(CFG_EPS, 64'd1);
        set_reg(CFG_DMIN, {16'd40, 16'd30, 16'd20, 16'd10});
        set_reg(CFG_DMAX, {16'd400, 16'd300, 16'd200, 16'd100});
        cfg_close();
        send_point(point_item(OP_OBSERVE, 10, 20, 30, 40));
        send_point(point_item(OP_OBSERVE, 100, 200, 300, 400));
        send_point(point_item(OP_QUERY, 9, 20, 30, 40));
        send_point(point_item(OP_QUERY, 100, 200, 300, 401));
        send_point(point_item(OP_QUERY, 11, 21, 31, 41));
        send_point(point_item(OP_QUERY, 12, 20, 30, 40));

        // Inverted bounds in lane 2: ignored while unused, rejecting once compared
        wait_drained();
        set_reg(CFG_DIMS, 64'd2);
        set_reg(CFG_DMIN, {16'd40, 16'd500, 16'd20, 16'd10});
        cfg_close();
        send_point(point_item(OP_OBSERVE, 50, 50, 0, 0));
        wait_drained();
        set_reg(CFG_DIMS, 64'd3);
        cfg_close();
        send_point(point_item(OP_QUERY, 50, 50, 400, 40));
        send_point(point_item(OP_OBSERVE, 50, 50, 400, 40));

        // Random phases; the table fills up between the rare clears
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            setup_phase();
            set_idle(phase % 4);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_point(pick_item());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** box_union_novelty_table_unit: PASSED **");
        else
            $display("** box_union_novelty_table_unit: FAILED **");
        $finish;
    end

endmodule
